>>> src/palette_luminance_remap_defines.svh
// ----------------------------------------------------------------------------
// palette_luminance_remap_defines
// Assertion macros used by the palette luminance remap RTL.
// ----------------------------------------------------------------------------
`ifndef PALETTE_LUMINANCE_REMAP_DEFINES_SVH
`define PALETTE_LUMINANCE_REMAP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PLR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/plr_pkg.sv
// ----------------------------------------------------------------------------
// plr_pkg
// Types, constants and the scale function of the palette luminance remap.
// ----------------------------------------------------------------------------
`default_nettype none

package plr_pkg;

	// palette geometry
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam logic [8:0] PAL_LIMIT = 9'(PAL_ENTRIES);

	// inverse palette: 5-5-5 rgb address
	localparam int CH_W      = 5;
	localparam int INV_AW    = 3 * CH_W;
	localparam int INV_DEPTH = 1 << INV_AW;

	localparam int COLOR_W = 24;
	localparam int SCALE_W = 10;
	localparam int PROD_W  = 8 + SCALE_W;
	localparam int SHIFT   = 11;

	localparam logic [7:0] PCT_PASS  = 8'd100;
	localparam logic [7:0] PCT_ZERO  = 8'd0;
	localparam logic [7:0] PCT_RESET = 8'd100;

	typedef enum logic [1:0] {
		ACT_PIXEL  = 2'd0,
		ACT_PAL_WR = 2'd1,
		ACT_INV_WR = 2'd2
	} action_t;

	typedef enum logic {
		REG_PERCENT = 1'b0,
		REG_BLACK   = 1'b1
	} reg_idx_t;

	// pct*255/100; the divide is a multiply by ceil(2^22/100), exact for every 8-bit percent
	function automatic logic [SCALE_W-1:0] scale_of(input logic [7:0] pct);
		logic [15:0] prod255;
		logic [31:0] prod;
		prod255 = {pct, 8'd0} - {8'd0, pct};
		prod    = 32'(prod255) * 32'd41944;
		return prod[22 +: SCALE_W];
	endfunction

	localparam logic [SCALE_W-1:0] SCALE_RESET = scale_of(PCT_RESET);

endpackage

`default_nettype wire

>>> src/plr_ram.sv
// ----------------------------------------------------------------------------
// plr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read
// that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module plr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> src/palette_luminance_remap.sv
// ----------------------------------------------------------------------------
// palette_luminance_remap
// Remaps palette-indexed pixels to darker or brighter palette indices through
// a palette store and a 5-5-5 inverse palette store.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on item_valid/item_stall. action selects a pixel, a palette
//   entry write (pixel_index, red, green, blue) or an inverse palette write
//   (inverse_address, inverse_value). Only pixels give a result transaction on
//   result_valid/result_stall, carrying pixel_out and last_out (frame_end).
//   Four-stage pipeline: palette read, channel scaling, inverse read, output
//   register. One item per cycle is accepted while the result side keeps up.
//   A result waiting under result_stall does not block input until every
//   stage holds an item; then item_stall rises and nothing is lost.
//   Registers: index 0 percent, index 1 black index, written over cfg_write
//   by the user only while no item is in flight; the block does not enforce
//   this. Reset empties the pipeline and sets percent to 100 and black index
//   to 0; the palette and inverse stores are not cleared and must be written
//   before use.
// ----------------------------------------------------------------------------
`default_nettype none

`include "palette_luminance_remap_defines.svh"

module palette_luminance_remap
	import plr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_write,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  pixel_index,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [14:0] inverse_address,
	input  wire logic [7:0]  inverse_value,
	input  wire logic        frame_end,

	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [7:0]       pixel_out,
	output logic             last_out
);

	// configuration
	logic               pass_q;
	logic               zero_q;
	logic [SCALE_W-1:0] scale_q;
	logic [7:0]         black_q;

	// stage load enables
	logic load1, load2, load3, load4;
	logic take;
	logic act_pix, act_pal, act_inv;
	logic in_range;

	// stage 1: palette read
	logic                 v_s1, pix_s1, range_s1, last_s1;
	logic [7:0]           pixel_s1, inv_val_s1;
	logic [INV_AW-1:0]    inv_addr_s1;
	logic [COLOR_W-1:0]   pal_rdata;

	// stage 2: scaled channels
	logic                 v_s2, pix_s2, last_s2;
	logic [7:0]           pixel_s2, inv_val_s2;
	logic [INV_AW-1:0]    inv_addr_s2;
	logic [CH_W-1:0]      r_s2, g_s2, b_s2;

	// stage 3: inverse read
	logic                 v_s3, last_s3;
	logic [7:0]           pixel_s3;
	logic [7:0]           inv_rdata;

	// stage 4: output
	logic                 v_s4, last_s4;
	logic [7:0]           pixel_s4;

	logic [COLOR_W-1:0]   color;
	logic [PROD_W-1:0]    r_prod, g_prod, b_prod;
	logic                 inv_we;

	assign load4 = !v_s4 || !result_stall;
	assign load3 = !v_s3 || load4;
	assign load2 = !v_s2 || load3;
	assign load1 = !v_s1 || load2;

	assign item_stall = !load1;
	assign take       = item_valid && load1;

	assign act_pix  = (action == ACT_PIXEL);
	assign act_pal  = (action == ACT_PAL_WR);
	assign act_inv  = (action == ACT_INV_WR);
	assign in_range = ({1'b0, pixel_index} < PAL_LIMIT);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q  <= 1'b1;
			zero_q  <= 1'b0;
			scale_q <= SCALE_RESET;
			black_q <= 8'd0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PERCENT: begin
					pass_q  <= (cfg_data == PCT_PASS);
					zero_q  <= (cfg_data == PCT_ZERO);
					scale_q <= scale_of(cfg_data);
				end
				REG_BLACK: begin
					black_q <= cfg_data;
				end
			endcase
		end
	end

	plr_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PAL_ENTRIES)
	) u_pal_ram (
		.clk     (clk),
		.wr_en   (take && act_pal && in_range),
		.wr_addr (pixel_index[PAL_AW-1:0]),
		.wr_data ({red, green, blue}),
		.rd_en   (load1),
		.rd_addr (pixel_index[PAL_AW-1:0]),
		.rd_data (pal_rdata)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (load1) begin
				v_s1 <= item_valid && (act_pix || act_inv);
			end
			if (load2) begin
				v_s2 <= v_s1;
			end
			if (load3) begin
				v_s3 <= v_s2 && pix_s2;
			end
			if (load4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// out-of-range pixels read as black color
	assign color  = range_s1 ? pal_rdata : '0;
	assign r_prod = PROD_W'(color[23:16]) * PROD_W'(scale_q);
	assign g_prod = PROD_W'(color[15:8])  * PROD_W'(scale_q);
	assign b_prod = PROD_W'(color[7:0])   * PROD_W'(scale_q);

	always_ff @(posedge clk) begin
		if (load1) begin
			pix_s1      <= act_pix;
			range_s1    <= in_range;
			last_s1     <= frame_end;
			pixel_s1    <= pixel_index;
			inv_addr_s1 <= inverse_address;
			inv_val_s1  <= inverse_value;
		end
		if (load2) begin
			pix_s2      <= pix_s1;
			last_s2     <= last_s1;
			pixel_s2    <= pixel_s1;
			inv_addr_s2 <= inv_addr_s1;
			inv_val_s2  <= inv_val_s1;
			r_s2        <= r_prod[SHIFT +: CH_W];
			g_s2        <= g_prod[SHIFT +: CH_W];
			b_s2        <= b_prod[SHIFT +: CH_W];
		end
		if (load3) begin
			last_s3  <= last_s2;
			pixel_s3 <= pixel_s2;
		end
		if (load4) begin
			last_s4 <= last_s3;
			if (pass_q) begin
				pixel_s4 <= pixel_s3;
			end else if (zero_q) begin
				pixel_s4 <= black_q;
			end else begin
				pixel_s4 <= inv_rdata;
			end
		end
	end

	// inverse writes happen in order with pixel reads, as the item leaves stage 2
	assign inv_we = load3 && v_s2 && !pix_s2;

	plr_ram #(
		.WIDTH (8),
		.DEPTH (INV_DEPTH)
	) u_inv_ram (
		.clk     (clk),
		.wr_en   (inv_we),
		.wr_addr (inv_addr_s2),
		.wr_data (inv_val_s2),
		.rd_en   (load3),
		.rd_addr ({r_s2, g_s2, b_s2}),
		.rd_data (inv_rdata)
	);

	assign result_valid = v_s4;
	assign pixel_out    = pixel_s4;
	assign last_out     = last_s4;

	`PLR_ASSERT_SAME(a_stall_only_when_full, item_stall,
		v_s1 && v_s2 && v_s3 && v_s4, "input stalled with a free pipeline stage")
	`PLR_ASSERT_NEXT(a_pixel_enters, item_valid && !item_stall && action == ACT_PIXEL,
		v_s1 && pix_s1, "accepted pixel did not enter stage 1")
	`PLR_ASSERT_NEXT(a_pal_write_no_slot, item_valid && !item_stall && action == ACT_PAL_WR,
		!v_s1, "palette write took a pipeline slot")
	`PLR_ASSERT_NEXT(a_inv_data_held, v_s3 && !load4,
		v_s3 && $stable(inv_rdata), "inverse read data lost while stage 3 stalled")

endmodule

`default_nettype wire
